[design/gbn_pkg.sv]
// Package for the go-back-N window engine: payload structs, op and kind codes,
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package gbn_pkg;

    localparam int HANDLE_WIDTH = 16;

    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_RECV  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_FIN    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic CFG_WINDOW_LIMIT = 1'b0;
    localparam logic CFG_RESEND_TICKS = 1'b1;

    localparam logic [5:0]  WINDOW_LIMIT_RESET = 6'd32;
    localparam logic [15:0] RESEND_TICKS_RESET = 16'd100;
    localparam logic [31:0] SERIAL_HALF        = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]              op;
        logic [HANDLE_WIDTH-1:0] msg_handle;
        logic [31:0]             rx_seq;
        logic [31:0]             rx_ack;
        logic                    rx_has_payload;
        logic                    rx_fin;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              kind;
        logic [31:0]             pkt_seq;
        logic [31:0]             pkt_ack;
        logic [HANDLE_WIDTH-1:0] pkt_handle;
        logic                    deliver;
        logic [HANDLE_WIDTH-1:0] delivered_handle;
        logic                    refused;
        logic                    closed;
        logic                    last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic push;      // write entry at tail, bump seq
        logic push_fin;  // entry is the FIN
        logic pop;       // drop head entry
        logic rd_head;   // read head entry
        logic rd_walk;   // read entry at walk offset
        logic walk_clr;  // reset walk offset to zero
        logic walk_inc;  // advance walk offset
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [31:0]             rd_seq;
        logic [HANDLE_WIDTH-1:0] rd_handle;
        logic                    rd_fin;
        logic [5:0]              count;
        logic [5:0]              walk;
        logic [31:0]             next_seq;
    } t_dp_sts;

endpackage
`default_nettype wire

[design/gbn_datapath.sv]
// Window store and pointers for the go-back-N engine.
// Depends on gbn_pkg; driven by gbn_ctrl commands.
`default_nettype none
module gbn_datapath import gbn_pkg::*; #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic [HANDLE_WIDTH-1:0] i_handle,
    output t_dp_sts                      o_sts
);
    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [31:0]           r_seq_mem [WINDOW_DEPTH];
    logic [HANDLE_WIDTH:0] r_hf_mem  [WINDOW_DEPTH];
    logic [AW-1:0] r_head;
    logic [5:0]    r_count, r_walk;
    logic [31:0]   r_next_seq;
    logic [31:0]   r_rd_seq;
    logic [HANDLE_WIDTH:0] r_rd_hf;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [5:0] off);
        logic [AW:0] s;
        s = {1'b0, h} + off[AW:0];
        if (s >= (AW+1)'(WINDOW_DEPTH)) s = s - (AW+1)'(WINDOW_DEPTH);
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] tail_idx, walk_idx, rd_idx;
    assign tail_idx = slot(r_head, r_count);
    assign walk_idx = slot(r_head, r_walk);
    assign rd_idx   = i_cmd.rd_walk ? walk_idx : r_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_seq_mem[tail_idx] <= r_next_seq + 32'd1;
            r_hf_mem[tail_idx]  <= {i_cmd.push_fin,
                                    i_cmd.push_fin ? {HANDLE_WIDTH{1'b0}} : i_handle};
        end
        if (i_cmd.rd_head || i_cmd.rd_walk) begin
            r_rd_seq <= r_seq_mem[rd_idx];
            r_rd_hf  <= r_hf_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_walk <= '0;
            r_next_seq <= '0;
        end else begin
            if (i_cmd.push) begin
                r_next_seq <= r_next_seq + 32'd1;
                r_count <= r_count + 6'd1;
            end else if (i_cmd.pop) begin
                r_head <= slot(r_head, 6'd1);
                r_count <= r_count - 6'd1;
            end
            if (i_cmd.walk_clr) r_walk <= '0;
            else if (i_cmd.walk_inc) r_walk <= r_walk + 6'd1;
        end
    end

    always_comb begin
        o_sts.rd_seq = r_rd_seq;
        o_sts.rd_handle = r_rd_hf[HANDLE_WIDTH-1:0];
        o_sts.rd_fin = r_rd_hf[HANDLE_WIDTH];
        o_sts.count = r_count;
        o_sts.walk = r_walk;
        o_sts.next_seq = r_next_seq;
    end
endmodule
`default_nettype wire

[design/gbn_ctrl.sv]
// Controller for the go-back-N engine: decodes items, sequences window
// releases and resend walks, builds result items. Depends on gbn_pkg.
`default_nettype none
module gbn_ctrl import gbn_pkg::*; #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_item,
    input  wire logic       i_item_valid,
    output logic            o_item_ready,
    output t_out_item       o_res,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    input  wire logic [5:0] i_window_limit,
    input  wire logic [15:0] i_resend_ticks,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_sts    i_sts
);
    typedef enum logic [2:0] {S_IDLE, S_REL_RD, S_REL_CHK, S_WALK_RD, S_WALK_EMIT,
                              S_OUT} t_state;

    t_state    r_state, n_state;
    t_in_item  r_item, n_item;
    t_out_item r_res, n_res;
    logic      r_res_valid, n_res_valid;
    logic [31:0] r_last_acc, n_last_acc;
    logic [15:0] r_idle, n_idle;
    logic r_fin_sent, n_fin_sent, r_fin_rcv, n_fin_rcv, r_closed, n_closed;

    logic [5:0] lim;
    logic [15:0] thr;
    logic full;
    logic [15:0] idle_inc;

    always_comb begin
        lim = i_window_limit;
        if (lim == 6'd0) lim = 6'd1;
        if (lim > 6'(WINDOW_DEPTH)) lim = 6'(WINDOW_DEPTH);
        thr = (i_resend_ticks == 16'd0) ? 16'd1 : i_resend_ticks;
        full = i_sts.count >= lim;
        idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    end

    function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return d < SERIAL_HALF;
    endfunction

    function automatic t_out_item status(input logic refused, input logic closed);
        t_out_item r;
        r = '0;
        r.kind = KIND_STATUS;
        r.refused = refused;
        r.closed = closed;
        r.last = 1'b1;
        return r;
    endfunction

    assign o_item_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_res = r_res;
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_res = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        n_last_acc = r_last_acc;
        n_idle = r_idle;
        n_fin_sent = r_fin_sent;
        n_fin_rcv = r_fin_rcv;
        n_closed = r_closed;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && o_item_ready) begin
                    n_item = i_item;
                    if (r_closed) begin
                        n_res = status(i_item.op == OP_SEND || i_item.op == OP_CLOSE, 1'b1);
                        n_res_valid = 1'b1;
                    end else begin
                        unique case (i_item.op)
                            OP_SEND: begin
                                if (r_fin_sent || full) begin
                                    n_res = status(1'b1, 1'b0);
                                end else begin
                                    o_cmd.push = 1'b1;
                                    n_res = '0;
                                    n_res.kind = KIND_DATA;
                                    n_res.pkt_seq = i_sts.next_seq + 32'd1;
                                    n_res.pkt_ack = r_last_acc;
                                    n_res.pkt_handle = i_item.msg_handle;
                                    n_res.last = 1'b1;
                                end
                                n_res_valid = 1'b1;
                            end
                            OP_CLOSE: begin
                                if (r_fin_sent) n_res = status(1'b0, 1'b0);
                                else if (full) n_res = status(1'b1, 1'b0);
                                else begin
                                    o_cmd.push = 1'b1;
                                    o_cmd.push_fin = 1'b1;
                                    n_fin_sent = 1'b1;
                                    n_res = '0;
                                    n_res.kind = KIND_FIN;
                                    n_res.pkt_seq = i_sts.next_seq + 32'd1;
                                    n_res.pkt_ack = r_last_acc;
                                    n_res.last = 1'b1;
                                    // FIN received and empty window cannot hold here
                                end
                                n_res_valid = 1'b1;
                            end
                            OP_RECV: begin
                                if (i_item.rx_fin) n_fin_rcv = 1'b1;
                                o_cmd.rd_head = 1'b1;
                                n_state = S_REL_CHK;
                            end
                            default: begin
                                n_idle = idle_inc;
                                if (idle_inc >= thr && i_sts.count != 6'd0) begin
                                    n_idle = '0;
                                    o_cmd.walk_clr = 1'b1;
                                    n_state = S_WALK_RD;
                                end else begin
                                    n_res = status(1'b0, 1'b0);
                                    n_res_valid = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_REL_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (i_sts.count != 6'd0 && at_or_before(i_sts.rd_seq, r_item.rx_ack)) begin
                    o_cmd.pop = 1'b1;
                    n_idle = '0;
                    n_state = S_REL_RD;
                end else begin
                    n_res = '0;
                    if (r_item.rx_seq == r_last_acc + 32'd1) begin
                        n_last_acc = r_item.rx_seq;
                        n_res.kind = KIND_ACK;
                        n_res.pkt_seq = i_sts.next_seq;
                        n_res.pkt_ack = r_item.rx_seq;
                        n_res.deliver = 1'b1;
                        n_res.delivered_handle = r_item.msg_handle;
                    end else if (at_or_before(r_item.rx_seq, r_last_acc) &&
                                 (r_item.rx_has_payload || r_item.rx_fin)) begin
                        n_res.kind = KIND_ACK;
                        n_res.pkt_seq = i_sts.next_seq;
                        n_res.pkt_ack = r_item.rx_seq;
                    end else begin
                        n_res.kind = KIND_STATUS;
                    end
                    n_closed = r_fin_sent && r_fin_rcv && i_sts.count == 6'd0;
                    n_res.closed = n_closed;
                    n_res.last = 1'b1;
                    n_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WALK_RD: begin
                o_cmd.rd_walk = 1'b1;
                n_state = S_WALK_EMIT;
            end
            S_WALK_EMIT: begin
                n_res = '0;
                n_res.kind = i_sts.rd_fin ? KIND_FIN : KIND_DATA;
                n_res.pkt_seq = i_sts.rd_seq;
                n_res.pkt_ack = r_last_acc;
                n_res.pkt_handle = i_sts.rd_fin ? 16'd0 : i_sts.rd_handle;
                n_res.last = (i_sts.walk + 6'd1) == i_sts.count;
                n_res_valid = 1'b1;
                o_cmd.walk_inc = 1'b1;
                n_state = n_res.last ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                // hold until the previous resend item leaves
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.rd_walk = 1'b1;
                    n_state = S_WALK_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_WALK_EMIT && r_res_valid && !i_res_ready) begin
            // previous result still waiting: stall emit
            o_cmd = '0;
            o_cmd.rd_walk = 1'b0;
            n_res = r_res;
            n_res_valid = 1'b1;
            n_state = S_WALK_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_valid <= 1'b0;
            r_last_acc <= '0;
            r_idle <= '0;
            r_fin_sent <= 1'b0;
            r_fin_rcv <= 1'b0;
            r_closed <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res_valid <= n_res_valid;
            r_last_acc <= n_last_acc;
            r_idle <= n_idle;
            r_fin_sent <= n_fin_sent;
            r_fin_rcv <= n_fin_rcv;
            r_closed <= n_closed;
        end
        r_item <= n_item;
        r_res <= n_res;
    end
endmodule
`default_nettype wire

[design/go_back_n_window_engine_unit.sv]
// Top level of the go-back-N window engine: config registers, controller
// and window datapath. Depends on gbn_pkg, gbn_ctrl, gbn_datapath.
`default_nettype none
// Go-back-N sequence and window engine. One item is taken at a time. A send,
// close or tick without resend is accepted, then its result item waits in
// the output register. A received packet reads the window head and compares
// it with the ack; each entry the ack releases is popped and costs one more
// read of the window memory followed by a compare. A resend tick walks the
// window oldest first through the single memory read port, giving one data
// or FIN item per entry with last set on the final one. The closed flag is
// set on the result of the received packet that closes the link; once the
// link closes every item gets one status result with it set. Configuration
// writes are taken at any time and should only come while the block is idle.
module go_back_n_window_engine_unit import gbn_pkg::*; #(
    parameter int WINDOW_DEPTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    output t_out_item      o_out_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [5:0]  r_window_limit;
    logic [15:0] r_resend_ticks;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    // hold the registers; write on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit <= WINDOW_LIMIT_RESET;
            r_resend_ticks <= RESEND_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LIMIT: r_window_limit <= i_cfg_data[5:0];
                CFG_RESEND_TICKS: r_resend_ticks <= i_cfg_data;
            endcase
        end
    end

    gbn_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_item(i_in_item), .i_item_valid(i_in_valid), .o_item_ready(o_in_ready),
        .o_res(o_out_item), .o_res_valid(o_out_valid), .i_res_ready(i_out_ready),
        .i_window_limit(r_window_limit), .i_resend_ticks(r_resend_ticks),
        .o_cmd(cmd), .i_sts(sts)
    );

    gbn_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_handle(i_in_item.msg_handle), .o_sts(sts)
    );

    // window count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.count <= 6'(WINDOW_DEPTH)) else $error("window overflow");
    // push and pop never in the same cycle
    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.pop)) else $error("push with pop");
    // an accepted item is never taken while a result waits
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("accept while result pending");
endmodule
`default_nettype wire
